>>> hdl/sample_playback_voice_macros.svh
// ----------------------------------------------------------------------------
// Sample playback voice assertion macros
// Shared macros for the concurrent checks of the sample playback voice.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_PLAYBACK_VOICE_MACROS_SVH
`define SAMPLE_PLAYBACK_VOICE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SPV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SPV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/spv_pkg.sv
// ----------------------------------------------------------------------------
// Sample playback voice package
// Opcodes, sequencer states and fixed constants of the playback voice.
// ----------------------------------------------------------------------------
package spv_pkg;

  // Item opcodes carried in the input tuser field.
  typedef enum logic [2:0] {
    OP_WRITE    = 3'd0,
    OP_TRIGGER  = 3'd1,
    OP_STOP     = 3'd2,
    OP_STEP     = 3'd3,
    OP_SPEED    = 3'd4,
    OP_FADE     = 3'd5,
    OP_FADE_ADD = 3'd6
  } spv_op_t;

  // Per-item sequencer states.
  typedef enum logic [2:0] {
    SPV_IDLE,
    SPV_VOL,
    SPV_RAMP,
    SPV_DIV,
    SPV_FIX,
    SPV_DONE
  } spv_state_t;

  // Position is Q15.8.
  localparam int FRAC_BITS = 8;
  localparam int POS_W     = 23;
  localparam int LEN_W     = 15;
  localparam int SAMP_W    = 16;

  // Unity volume in Q1.15.
  localparam logic [15:0] UNITY_VOL = 16'h8000;

  // Reciprocal shift used for the divide by the fade length.
  localparam int DIV_SHIFT = 21;
  localparam int RECIP_W   = 22;

  // Wide address used before selecting the memory index bits.
  localparam int ADDR_EXT_W = 21;

endpackage

>>> hdl/sample_playback_voice.sv
// ----------------------------------------------------------------------------
// Sample playback voice
// One-shot sampler voice with a sample memory, plain, variable-speed and
// faded ticks, Q1.15 volume scaling and 16-bit saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the in_ channel: in_tuser holds the opcode, in_tdata the
//   address, sample word, velocity, speed and mix value. Every item gives
//   exactly one result item on the out_ channel: the output sample, the
//   playing flag and the integer play position after the item.
//   The cfg_ port writes the sample length; it also rewinds the voice, stops
//   it and sets unity volume. Write it only while no item is in flight.
// Sequencing:
//   Ticks that read a sample word run through the memory read, the volume
//   multiply, the ramp multiply, a reciprocal divide and its correction,
//   then the output register. Writes, triggers, stops and ticks that play
//   nothing go straight to the output register. The sequencer works on one
//   item at a time: the next item is taken only after the result is loaded.
// Reset:
//   rst_n is synchronous, active low. It stops the voice, clears the position
//   and the length and sets unity volume. Sample memory is not cleared.
// Back-pressure:
//   A finished result sits in the output register until taken; a new item is
//   accepted meanwhile, and its result waits in the last stage if needed.
// ----------------------------------------------------------------------------
module sample_playback_voice #(
  parameter int MEM_DEPTH = 16384,
  parameter int FADE_LEN  = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input item channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata fields from bit 0: address[13:0], sample_value[15:0],
  // velocity[15:0], speed[15:0], mix_in[15:0], two zero pad bits.
  input  logic [79:0] in_tdata,
  // tuser fields from bit 0: opcode[2:0].
  input  logic [2:0]  in_tuser,
  // Result item channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata fields from bit 0: sample_out[15:0], is_playing, play_index[14:0].
  output logic [31:0] out_tdata,
  // Sample length register.
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data
);

  import spv_pkg::*;

  localparam int AW    = $clog2(MEM_DEPTH);
  localparam int KW    = $clog2(FADE_LEN + 1);
  localparam int PKW   = 33 + KW;
  localparam int LIM   = FADE_LEN * 32768;
  localparam int QW    = $clog2(LIM + 1);
  localparam int RECIP = (2 ** DIV_SHIFT) / FADE_LEN;

  localparam logic [QW-1:0]      LIM_Q   = QW'(LIM);
  localparam logic [QW-1:0]      FADE_Q  = QW'(FADE_LEN);
  localparam logic [QW:0]        TWO_F   = (QW + 1)'(2 * FADE_LEN);
  localparam logic [KW-1:0]      FADE_K  = KW'(FADE_LEN);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  // Input field unpacking.
  spv_op_t            op;
  logic [13:0]        in_address;
  logic signed [15:0] in_sample_value;
  logic [15:0]        in_velocity;
  logic [15:0]        in_speed;
  logic signed [15:0] in_mix_in;

  assign op              = spv_op_t'(in_tuser);
  assign in_address      = in_tdata[13:0];
  assign in_sample_value = in_tdata[29:14];
  assign in_velocity     = in_tdata[45:30];
  assign in_speed        = in_tdata[61:46];
  assign in_mix_in       = in_tdata[77:62];

  // Voice state and control registers.
  spv_state_t         state_r, state_nxt;
  logic [POS_W-1:0]   play_pos_r;
  logic               playing_r;
  logic [15:0]        vol_r;
  logic [LEN_W-1:0]   len_r;
  logic               out_valid_r;
  logic               in_accept;
  logic               out_load;

  // Job registers for the item in flight.
  logic               job_voice_r;
  logic               job_mix_r;
  logic [KW-1:0]      job_k_r;
  logic signed [15:0] job_mix_val_r;

  // Datapath registers.
  logic signed [15:0]  mem_rdata_r;
  logic signed [32:0]  prod_vw_r;
  logic signed [PKW-1:0] prod_k_r;
  logic [QW-1:0]       q_r;
  logic [QW-1:0]       est_r;
  logic                neg_r;
  logic signed [15:0]  voice_r;

  // Output registers.
  logic signed [15:0]  out_sample_r;
  logic                out_playing_r;
  logic [LEN_W-1:0]    out_index_r;

  // Sample memory.
  logic signed [15:0] sample_mem [0:MEM_DEPTH-1];

  // Length clipped to the memory size.
  logic [LEN_W-1:0] eff_len;
  assign eff_len = (ADDR_EXT_W'(len_r) > ADDR_EXT_W'(MEM_DEPTH)) ?
                   LEN_W'(MEM_DEPTH) : len_r;

  // Position helpers for the decode of one item.
  logic [POS_W-1:0] lenq;
  logic [POS_W-1:0] end_q;
  logic [LEN_W-1:0] pos_i;
  logic [POS_W-1:0] pos_plus1;
  logic [POS_W:0]   spd_sum;
  logic             fade_adv;
  logic [KW-1:0]    fade_k;
  logic [POS_W-1:0] fade_pos;

  assign lenq      = {eff_len, {FRAC_BITS{1'b0}}};
  assign end_q     = {eff_len - LEN_W'(1), {FRAC_BITS{1'b0}}};
  assign pos_i     = play_pos_r[POS_W-1:FRAC_BITS];
  assign pos_plus1 = play_pos_r + POS_W'(1 << FRAC_BITS);
  assign spd_sum   = {1'b0, play_pos_r} + (POS_W + 1)'(in_speed);
  assign fade_adv  = pos_i < eff_len;
  assign fade_pos  = fade_adv ? pos_plus1 : play_pos_r;

  // Ramp weight: rising over the first samples, falling over the last ones.
  always_comb begin
    if (pos_i < LEN_W'(FADE_LEN)) begin
      fade_k = KW'(pos_i) + KW'(1);
    end else if ((16'(pos_i) + 16'(FADE_LEN)) > 16'(eff_len)) begin
      fade_k = KW'(eff_len - pos_i);
    end else begin
      fade_k = FADE_K;
    end
  end

  // Item decode: next voice state and what the datapath has to do.
  logic [POS_W-1:0] pos_dec;
  logic             playing_dec;
  logic [15:0]      vol_dec;
  logic             voice_dec;
  logic             mix_dec;
  logic [KW-1:0]    k_dec;
  logic [LEN_W-1:0] idx_dec;
  logic             len_zero;

  assign len_zero = (eff_len == '0);

  always_comb begin
    pos_dec     = play_pos_r;
    playing_dec = playing_r;
    vol_dec     = vol_r;
    voice_dec   = 1'b0;
    mix_dec     = 1'b0;
    k_dec       = FADE_K;
    idx_dec     = pos_i;
    unique case (op)
      OP_WRITE: begin
      end
      OP_TRIGGER: begin
        vol_dec     = in_velocity;
        pos_dec     = '0;
        playing_dec = 1'b1;
      end
      OP_STOP: begin
        pos_dec     = '0;
        playing_dec = 1'b0;
      end
      OP_STEP: begin
        if (!len_zero) begin
          if (playing_r && (play_pos_r < lenq)) begin
            voice_dec = 1'b1;
            pos_dec   = pos_plus1;
          end else begin
            playing_dec = 1'b0;
          end
        end
      end
      OP_SPEED: begin
        if (!len_zero) begin
          if (playing_r && (spd_sum < {1'b0, lenq})) begin
            voice_dec = 1'b1;
            pos_dec   = spd_sum[POS_W-1:0];
            idx_dec   = spd_sum[POS_W-1:FRAC_BITS];
          end else begin
            playing_dec = 1'b0;
          end
        end
      end
      OP_FADE: begin
        if (!len_zero) begin
          voice_dec = fade_adv;
          k_dec     = fade_k;
          pos_dec   = fade_pos;
          if (fade_pos >= end_q) begin
            playing_dec = 1'b0;
          end
        end
      end
      OP_FADE_ADD: begin
        mix_dec = 1'b1;
        if (!len_zero) begin
          voice_dec = fade_adv;
          k_dec     = fade_k;
          pos_dec   = fade_pos;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SPV_IDLE: begin
        if (in_tvalid) begin
          state_nxt = voice_dec ? SPV_VOL : SPV_DONE;
        end
      end
      SPV_VOL:  state_nxt = SPV_RAMP;
      SPV_RAMP: state_nxt = SPV_DIV;
      SPV_DIV:  state_nxt = SPV_FIX;
      SPV_FIX:  state_nxt = SPV_DONE;
      SPV_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = SPV_IDLE;
        end
      end
      default:  state_nxt = SPV_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      SPV_IDLE: in_tready = 1'b1;
      SPV_DONE: out_load  = !out_valid_r || out_tready;
      default: begin
      end
    endcase
  end

  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SPV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Voice state: configuration write rewinds; accepted items update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_pos_r <= '0;
      playing_r  <= 1'b0;
      vol_r      <= UNITY_VOL;
      len_r      <= '0;
    end else if (cfg_wr_en) begin
      len_r      <= cfg_wr_data;
      play_pos_r <= '0;
      playing_r  <= 1'b0;
      vol_r      <= UNITY_VOL;
    end else if (in_accept) begin
      play_pos_r <= pos_dec;
      playing_r  <= playing_dec;
      vol_r      <= vol_dec;
    end
  end

  // Job capture at acceptance.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      job_voice_r   <= voice_dec;
      job_mix_r     <= mix_dec;
      job_k_r       <= k_dec;
      job_mix_val_r <= in_mix_in;
    end
  end

  // Sample memory: write for the write opcode, registered read for ticks.
  logic [ADDR_EXT_W-1:0] wr_addr_ext;
  logic [ADDR_EXT_W-1:0] rd_addr_ext;
  logic                  mem_we;

  assign wr_addr_ext = ADDR_EXT_W'(in_address);
  assign rd_addr_ext = ADDR_EXT_W'(idx_dec);
  assign mem_we      = in_accept && (op == OP_WRITE) &&
                       (wr_addr_ext < ADDR_EXT_W'(MEM_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_mem[wr_addr_ext[AW-1:0]] <= in_sample_value;
    end
    if (in_accept && voice_dec) begin
      mem_rdata_r <= sample_mem[rd_addr_ext[AW-1:0]];
    end
  end

  // Volume times sample word.
  logic signed [32:0] vol_s;
  logic signed [32:0] word_s;
  assign vol_s  = $signed({17'd0, vol_r});
  assign word_s = {{17{mem_rdata_r[15]}}, mem_rdata_r};

  always_ff @(posedge clk) begin
    if (state_r == SPV_VOL) begin
      prod_vw_r <= vol_s * word_s;
    end
  end

  // Ramp weight multiply.
  logic signed [PKW-1:0] vw_ext;
  logic signed [PKW-1:0] k_ext;
  assign vw_ext = PKW'(prod_vw_r);
  assign k_ext  = $signed(PKW'(job_k_r));

  always_ff @(posedge clk) begin
    if (state_r == SPV_RAMP) begin
      prod_k_r <= vw_ext * k_ext;
    end
  end

  // Magnitude over 32768, clamped at the saturation point, then divided by
  // the fade length through a reciprocal estimate.
  logic [PKW-1:0]         mag_p;
  logic [PKW-1:0]         mag_sh;
  logic [QW-1:0]          q_clamp;
  logic [QW+RECIP_W-1:0]  est_prod;

  assign mag_p    = prod_k_r[PKW-1] ? PKW'(-prod_k_r) : PKW'(prod_k_r);
  assign mag_sh   = mag_p >> 15;
  assign q_clamp  = (mag_sh > PKW'(LIM)) ? LIM_Q : mag_sh[QW-1:0];
  assign est_prod = (QW + RECIP_W)'(q_clamp) * (QW + RECIP_W)'(RECIP_C);

  always_ff @(posedge clk) begin
    if (state_r == SPV_DIV) begin
      q_r   <= q_clamp;
      est_r <= QW'(est_prod >> DIV_SHIFT);
      neg_r <= prod_k_r[PKW-1];
    end
  end

  // The estimate is low by at most one; correct it and saturate.
  logic [QW-1:0] fix_rem;
  logic [16:0]   fix_mag;
  logic [16:0]   fix_neg;

  assign fix_rem = q_r - QW'(est_r * FADE_Q);
  assign fix_mag = 17'(est_r) + ((fix_rem >= FADE_Q) ? 17'd1 : 17'd0);
  assign fix_neg = 17'd0 - fix_mag;

  always_ff @(posedge clk) begin
    if (state_r == SPV_FIX) begin
      if (neg_r) begin
        voice_r <= fix_neg[15:0];
      end else if (fix_mag > 17'd32767) begin
        voice_r <= 16'sd32767;
      end else begin
        voice_r <= fix_mag[15:0];
      end
    end
  end

  // Final sample: voice alone or added to the mix value with saturation.
  logic signed [15:0] voice_sel;
  logic signed [16:0] mix_sum;
  logic signed [15:0] final_sample;

  assign voice_sel = job_voice_r ? voice_r : 16'sd0;
  assign mix_sum   = 17'(job_mix_val_r) + 17'(voice_sel);

  always_comb begin
    if (!job_mix_r) begin
      final_sample = voice_sel;
    end else if (mix_sum > 17'sd32767) begin
      final_sample = 16'sh7fff;
    end else if (mix_sum < -17'sd32768) begin
      final_sample = 16'sh8000;
    end else begin
      final_sample = mix_sum[15:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r  <= final_sample;
      out_playing_r <= playing_r;
      out_index_r   <= play_pos_r[POS_W-1:FRAC_BITS];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_index_r, out_playing_r, out_sample_r};

  // Checks.
  `include "sample_playback_voice_macros.svh"

  `SPV_ASSERT_IMP(a_pos_in_range, clk, rst_n, 1'b1, play_pos_r[POS_W-1:FRAC_BITS] <= eff_len, "play position beyond sample length")
  `SPV_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_tvalid && in_tready, state_r != SPV_IDLE, "sequencer stayed idle after accepting an item")
  `SPV_ASSERT_IMP(a_div_correction, clk, rst_n, state_r == SPV_FIX, {1'b0, fix_rem} < TWO_F, "reciprocal divide estimate off by more than one")
  `SPV_ASSERT_NXT(a_done_waits, clk, rst_n, (state_r == SPV_DONE) && out_tvalid && !out_tready, state_r == SPV_DONE, "result dropped while output stalled")

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Sample playback voice testbench
// Drives opcode items into the voice and writes the sample length register
// between phases. A scoreboard keeps its own copy of the memory, position,
// volume and playing flag, works out the result of every accepted item and
// compares it field by field with the results that leave the block. Before a
// tick that would read a word that was never written, the stimulus writes
// that word first. Both the input and the result side idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spv_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int VOICE_DEPTH = 16384;
  localparam int RAMP_LEN    = 3;
  localparam int ITEM_TARGET = 1150;
  localparam int REPORT_MAX  = 10;

  // One input item, unpacked from in_tdata and in_tuser.
  typedef struct {
    spv_op_t            op;
    logic [13:0]        address;
    logic signed [15:0] sample_value;
    logic [15:0]        velocity;
    logic [15:0]        speed;
    logic signed [15:0] mix_in;
  } voice_item_t;

  // One result item, laid out as out_tdata.
  typedef struct packed {
    logic [14:0]        play_index;
    logic               is_playing;
    logic signed [15:0] sample_out;
  } voice_result_t;

  // Tracks the voice state and the results still owed by the block.
  class voice_scoreboard;
    logic signed [15:0] sample_words [VOICE_DEPTH];
    bit                 word_written [VOICE_DEPTH];
    int unsigned        position;
    bit                 playing;
    int unsigned        volume;
    int unsigned        length;
    voice_result_t      results_due [$];
    int                 mismatches;

    function new();
      position   = 0;
      playing    = 1'b0;
      volume     = UNITY_VOL;
      length     = 0;
      mismatches = 0;
    endfunction

    // A length write also rewinds and stops the voice at unity volume.
    function void set_length(logic [14:0] value);
      length   = (value > VOICE_DEPTH) ? VOICE_DEPTH : value;
      position = 0;
      playing  = 1'b0;
      volume   = UNITY_VOL;
    endfunction

    function longint clip16(longint value);
      if (value > 32767) return 32767;
      if (value < -32768) return -32768;
      return value;
    endfunction

    // Volume times word times weight over the full ramp scale, toward zero.
    function longint scaled_word(int unsigned index, longint weight);
      longint product;
      product = longint'(volume) * longint'(sample_words[index]) * weight;
      return clip16(product / (longint'(RAMP_LEN) * 32768));
    endfunction

    // One faded sample: the ramps are linear over the first and last words.
    function longint faded_voice();
      int unsigned index;
      longint      weight;
      index = position >> FRAC_BITS;
      if (index >= length) return 0;
      if (index < RAMP_LEN) weight = index + 1;
      else if (index + RAMP_LEN > length) weight = length - index;
      else weight = RAMP_LEN;
      position += 1 << FRAC_BITS;
      return scaled_word(index, weight);
    endfunction

    // Index of the word that an item would read now, or -1 for none.
    function int word_read_by(voice_item_t item);
      int unsigned span;
      span = length << FRAC_BITS;
      if (length == 0) return -1;
      case (item.op)
        OP_STEP: begin
          if (playing && position < span) return int'(position >> FRAC_BITS);
        end
        OP_SPEED: begin
          if (playing && position + item.speed < span)
            return int'((position + item.speed) >> FRAC_BITS);
        end
        OP_FADE, OP_FADE_ADD: begin
          if ((position >> FRAC_BITS) < length) return int'(position >> FRAC_BITS);
        end
        default: ;
      endcase
      return -1;
    endfunction

    // Applies an accepted item and queues the result it must produce.
    function void note_item(voice_item_t item);
      longint        voice;
      int unsigned   span;
      voice_result_t due;
      voice = 0;
      span  = length << FRAC_BITS;
      case (item.op)
        OP_WRITE: begin
          sample_words[item.address] = item.sample_value;
          word_written[item.address] = 1'b1;
        end
        OP_TRIGGER: begin
          volume   = item.velocity;
          position = 0;
          playing  = 1'b1;
        end
        OP_STOP: begin
          playing  = 1'b0;
          position = 0;
        end
        OP_STEP: begin
          if (length != 0) begin
            if (playing && position < span) begin
              voice = scaled_word(position >> FRAC_BITS, RAMP_LEN);
              position += 1 << FRAC_BITS;
            end else begin
              playing = 1'b0;
            end
          end
        end
        OP_SPEED: begin
          if (length != 0) begin
            if (playing && position + item.speed < span) begin
              position += item.speed;
              voice = scaled_word(position >> FRAC_BITS, RAMP_LEN);
            end else begin
              playing = 1'b0;
            end
          end
        end
        OP_FADE: begin
          if (length != 0) begin
            voice = faded_voice();
            if (position >= ((length - 1) << FRAC_BITS)) playing = 1'b0;
          end
        end
        OP_FADE_ADD: begin
          if (length == 0) voice = item.mix_in;
          else voice = clip16(longint'(item.mix_in) + faded_voice());
        end
        default: ;
      endcase
      due.sample_out = voice[15:0];
      due.is_playing = playing;
      due.play_index = 15'(position >> FRAC_BITS);
      results_due.push_back(due);
    endfunction

    function void report(string what, voice_result_t due, voice_result_t got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("ERROR at %0t: %s: sample_out exp %0d got %0d, is_playing exp %0b got %0b, play_index exp %0d got %0d",
                 $realtime, what, due.sample_out, got.sample_out, due.is_playing,
                 got.is_playing, due.play_index, got.play_index);
    endfunction

    // Compares a result taken from the block with the oldest one owed.
    function void check_result(logic [31:0] word);
      voice_result_t got;
      voice_result_t due;
      got = word;
      if (results_due.size() == 0) begin
        due = '0;
        report("result with no item pending", due, got);
        return;
      end
      due = results_due.pop_front();
      if (got.sample_out !== due.sample_out || got.is_playing !== due.is_playing ||
          got.play_index !== due.play_index)
        report("result differs", due, got);
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function bit clean();
      return mismatches == 0 && results_due.size() == 0;
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata    = '0;
  logic [2:0]  in_tuser    = OP_WRITE;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic [14:0] cfg_wr_data = '0;

  voice_scoreboard board;
  int              items_sent = 0;
  bit              steady     = 1'b0;

  sample_playback_voice #(
    .MEM_DEPTH(VOICE_DEPTH),
    .FADE_LEN (RAMP_LEN)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // Sample words lean toward the extremes to reach the saturating paths.
  function automatic logic [15:0] random_word();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'h8000;
    if (roll == 1) return 16'h7fff;
    return 16'($urandom_range(0, 16'hffff));
  endfunction

  // All fields random; the ones the opcode ignores still toggle.
  function automatic voice_item_t random_item(spv_op_t op);
    voice_item_t item;
    int          roll;
    item.op           = op;
    item.address      = 14'($urandom_range(0, VOICE_DEPTH - 1));
    item.sample_value = random_word();
    item.mix_in       = random_word();
    roll = $urandom_range(0, 19);
    if (roll < 3) item.velocity = UNITY_VOL;
    else if (roll < 5) item.velocity = '0;
    else item.velocity = 16'($urandom_range(0, 32768));
    roll = $urandom_range(0, 9);
    if (roll < 5) item.speed = 16'($urandom_range(0, 600));
    else if (roll == 5) item.speed = '0;
    else item.speed = 16'($urandom_range(0, 16'hffff));
    return item;
  endfunction

  function automatic spv_op_t pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return OP_TRIGGER;
    if (roll < 30) return OP_STEP;
    if (roll < 44) return OP_SPEED;
    if (roll < 64) return OP_FADE;
    if (roll < 80) return OP_FADE_ADD;
    if (roll < 85) return OP_STOP;
    return OP_WRITE;
  endfunction

  // Presents one item and waits until the block takes it.
  task automatic send_item(voice_item_t item);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, item.mix_in, item.speed, item.velocity, item.sample_value,
                  item.address};
    in_tuser  <= item.op;
    do @(posedge clk); while (!in_tready);
    board.note_item(item);
    items_sent++;
  endtask

  // A tick that would read an unwritten word gets that word written first.
  task automatic play_item(voice_item_t item);
    int          index;
    voice_item_t fill;
    index = board.word_read_by(item);
    if (index >= 0 && !board.word_written[index]) begin
      fill = random_item(OP_WRITE);
      fill.address = 14'(index);
      send_item(fill);
    end
    send_item(item);
  endtask

  // The argument lands in the value field the opcode uses; writes also take the address.
  task automatic drive_op(spv_op_t op, int arg, int addr = 0);
    voice_item_t item;
    item = random_item(op);
    case (op)
      OP_WRITE: begin
        item.address      = addr[13:0];
        item.sample_value = arg[15:0];
      end
      OP_TRIGGER:  item.velocity = arg[15:0];
      OP_SPEED:    item.speed    = arg[15:0];
      OP_FADE_ADD: item.mix_in   = arg[15:0];
      default: ;
    endcase
    play_item(item);
  endtask

  // The length is written only once every owed result has left the block.
  task automatic write_length(int value);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[14:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_length(value[14:0]);
  endtask

  // One phase: a new length, then a run of mostly playback items.
  task automatic random_phase();
    int roll;
    int count;
    roll = $urandom_range(0, 99);
    if (roll < 8) write_length(0);
    else if (roll < 18) write_length(VOICE_DEPTH);
    else if (roll < 30) write_length($urandom_range(1, VOICE_DEPTH - 1));
    else write_length($urandom_range(1, 24));
    steady = ($urandom_range(0, 4) == 0);
    count  = $urandom_range(20, 60);
    repeat (count) play_item(random_item(pick_op()));
  endtask

  // Result side: check every taken result, then pick the next ready level.
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        stall = idle_cycles();
      end
    end
  end

  initial begin : stimulus
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No sample loaded: every tick gives zero, the faded add passes the mix.
    write_length(0);
    drive_op(OP_STEP, 0);
    drive_op(OP_SPEED, 65535);
    drive_op(OP_FADE, 0);
    drive_op(OP_FADE_ADD, -32768);

    // A five-word sample of alternating full-scale words.
    write_length(5);
    drive_op(OP_WRITE, -32768, VOICE_DEPTH - 1);
    for (int n = 0; n < 5; n++) drive_op(OP_WRITE, (n % 2) ? -32768 : 32767, n);
    drive_op(OP_TRIGGER, 32768);
    // The ramped first word on top of a full-scale mix saturates.
    drive_op(OP_FADE_ADD, 32767);
    // Through the rising ramp, the falling ramp and one tick past the end.
    repeat (5) drive_op(OP_FADE, 0);
    // Plain steps at half volume, the last one running off the end.
    drive_op(OP_TRIGGER, 16384);
    repeat (6) drive_op(OP_STEP, 0);
    // Fractional speed, then a step too large for the sample.
    drive_op(OP_TRIGGER, 32768);
    drive_op(OP_SPEED, 384);
    drive_op(OP_SPEED, 65535);
    drive_op(OP_STOP, 0);

    while (items_sent < ITEM_TARGET) random_phase();

    in_tvalid <= 1'b0;
    steady = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.clean()) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hang guard, several times the slowest correct run.
  initial begin : watchdog
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
